### rtl/gamepad_axis_throttle_mapper_defines.svh
// ----------------------------------------------------------------------------
// Gamepad axis throttle mapper: assertion macros
// Shared assertion macros, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_AXIS_THROTTLE_MAPPER_DEFINES_SVH
`define GAMEPAD_AXIS_THROTTLE_MAPPER_DEFINES_SVH

// Checks a property at every rising edge outside of reset.
`define GATM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define GATM_ASSERT_NEVER(lbl, cond, msg) \
  `GATM_ASSERT(lbl, !(cond), msg)

`endif

### rtl/gatm_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad axis throttle mapper package
// Types and constants shared by the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gatm_pkg;

  // Number of stick bytes in a report, and events the merge stage can hold.
  localparam int NUM_STICKS = 4;
  localparam int NUM_EVENTS = 4;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 8;
  localparam int VALUE_W = 9;
  localparam int HALF_W  = 7;
  localparam int PROD_W  = 14;
  localparam int RECIP_W = 15;

  // Dead zone bounds and the power register's reset value.
  localparam logic [BYTE_W-1:0] DZ_LOW       = 8'h70;
  localparam logic [BYTE_W-1:0] DZ_HIGH      = 8'h90;
  localparam logic [BYTE_W-1:0] POWER_RESET  = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_RESET   = 8'hFF;
  localparam logic [BYTE_W-1:0] BTN_LEFT     = 8'h01;
  localparam logic [BYTE_W-1:0] BTN_RIGHT    = 8'h02;

  // Reciprocal of the span 111: floor(x * 18894 / 2^21) equals x / 111 for
  // every product below 2^14.
  localparam logic [RECIP_W-1:0] SPAN_RECIP  = 15'd18894;
  localparam int                 RECIP_SHIFT = 21;

  // Event kinds, also the event's slot in the merge stage.
  typedef enum logic [1:0] {
    KIND_X      = 2'd0,
    KIND_Y      = 2'd1,
    KIND_Z      = 2'd2,
    KIND_BUTTON = 2'd3
  } kind_e;

  // Where a stick byte lies relative to the dead zone.
  typedef enum logic [1:0] {
    ZONE_DEAD = 2'd0,
    ZONE_LOW  = 2'd1,
    ZONE_HIGH = 2'd2
  } zone_e;

  // Stage enables handed to every lane.
  typedef struct packed {
    logic en1;  // input transfer, lane stage 1 loads
    logic en2;  // stage 1 moves into stage 2
    logic en3;  // stage 2 moves into the merge stage
  } lane_ctrl_t;

  // What a lane reports from its stage 2.
  typedef struct packed {
    logic                      fire;
    logic signed [LEVEL_W-1:0] level;
  } lane_stat_t;

  // Merge stage status toward the pipeline control.
  typedef struct packed {
    logic slot_free;
    logic load;
    logic pending;
  } merge_stat_t;

endpackage

### rtl/gatm_lane.sv
// ----------------------------------------------------------------------------
// Gamepad axis throttle mapper: stick lane
// Change detection and throttle level of one stick byte in two stages, plus
// the last level kept for that stick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gatm_lane import gatm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctrl_t          ctrl_i,
  input  logic [BYTE_W-1:0]   byte_i,
  input  logic [HALF_W-1:0]   half_power_i,
  output lane_stat_t          stat_o
);

  logic [BYTE_W-1:0]         prev_byte_q;
  logic signed [LEVEL_W-1:0] prev_level_q;

  logic                      chg1_q, chg1_d;
  zone_e                     zone1_q, zone1_d;
  logic [PROD_W-1:0]         prod1_q, prod1_d;
  logic [HALF_W-1:0]         half1_q;

  logic                      chg2_q;
  logic signed [LEVEL_W-1:0] level2_q, level2_d;

  logic [LEVEL_W-1:0]        mul_a;
  logic [HALF_W-1:0]         mul_b;
  logic [PROD_W:0]           prod_full;
  logic [PROD_W+RECIP_W-1:0] recip_full;
  logic [LEVEL_W-1:0]        quot;

  // Stage 1: classify the byte and form the dividend.
  always_comb begin
    chg1_d = (byte_i != prev_byte_q);
    if (byte_i > DZ_HIGH) begin
      zone1_d = ZONE_HIGH;
      mul_a   = {1'b0, half_power_i} + 8'd1;
      mul_b   = HALF_W'(byte_i - DZ_HIGH);
    end else if (byte_i >= DZ_LOW) begin
      zone1_d = ZONE_DEAD;
      mul_a   = '0;
      mul_b   = '0;
    end else begin
      zone1_d = ZONE_LOW;
      mul_a   = {1'b0, half_power_i};
      mul_b   = byte_i[HALF_W-1:0];
    end
    prod_full = (PROD_W+1)'(mul_a) * (PROD_W+1)'(mul_b);
    prod1_d   = prod_full[PROD_W-1:0];
  end

  // Stage 2: divide by the span through the reciprocal and form the level.
  always_comb begin
    recip_full = (PROD_W+RECIP_W)'(prod1_q) * (PROD_W+RECIP_W)'(SPAN_RECIP);
    quot       = recip_full[RECIP_SHIFT +: LEVEL_W];
    unique case (zone1_q)
      ZONE_HIGH: level2_d = LEVEL_W'(8'd0 - quot);
      ZONE_LOW:  level2_d = LEVEL_W'({1'b0, half1_q} - quot);
      default:   level2_d = '0;
    endcase
  end

  // A level counts as new only if the byte changed and the level moved.
  assign stat_o.fire  = chg2_q && (level2_q != prev_level_q);
  assign stat_o.level = level2_q;

  // Stick history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_byte_q  <= BYTE_RESET;
      prev_level_q <= '0;
    end else begin
      if (ctrl_i.en1) begin
        prev_byte_q <= byte_i;
      end
      if (ctrl_i.en3 && stat_o.fire) begin
        prev_level_q <= level2_q;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      chg1_q  <= chg1_d;
      zone1_q <= zone1_d;
      prod1_q <= prod1_d;
      half1_q <= half_power_i;
    end
    if (ctrl_i.en2) begin
      chg2_q   <= chg1_q;
      level2_q <= level2_d;
    end
  end

endmodule

### rtl/gatm_merge.sv
// ----------------------------------------------------------------------------
// Gamepad axis throttle mapper: merge stage
// Gathers the events of one report from the lanes and the button path and
// hands them to the output register one per cycle while the output does not stall, in axis order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gatm_merge import gatm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s2_valid_i,
  input  lane_stat_t                lane_i [NUM_STICKS],
  input  logic                      btn_emit_i,
  input  logic                      btn_val_i,
  output merge_stat_t               stat_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                event_kind_o,
  output logic signed [VALUE_W-1:0] event_value_o,
  output logic                      last_event_o
);

  logic [NUM_EVENTS-1:0]     mask_q, mask_d;
  logic [NUM_EVENTS-1:0]     new_mask;
  logic [NUM_EVENTS-1:0]     pending_after;
  logic [NUM_EVENTS-1:0]     sel_onehot;
  logic [VALUE_W-1:0]        vals_q [NUM_EVENTS];
  logic [VALUE_W-1:0]        vals_d [NUM_EVENTS];
  logic [VALUE_W-1:0]        level_x, level_y, level_z;
  kind_e                     sel;
  logic                      out_load, emit;

  logic                      out_valid_q, out_valid_d;
  kind_e                     kind_q;
  logic [VALUE_W-1:0]        value_q;
  logic                      last_q;

  // Events that the report in stage 2 brings along; right stick Y is silent.
  always_comb begin
    level_x = {lane_i[0].level[LEVEL_W-1], lane_i[0].level};
    level_y = {lane_i[1].level[LEVEL_W-1], lane_i[1].level};
    level_z = {lane_i[2].level[LEVEL_W-1], lane_i[2].level};
    new_mask = {btn_emit_i, lane_i[2].fire, lane_i[1].fire, lane_i[0].fire};
    vals_d[KIND_X]      = level_x;
    vals_d[KIND_Y]      = 9'd0 - level_y;
    vals_d[KIND_Z]      = 9'd0 - level_z;
    vals_d[KIND_BUTTON] = {8'd0, btn_val_i};
  end

  // Pick the lowest pending event.
  always_comb begin
    sel = KIND_BUTTON;
    for (int k = NUM_EVENTS - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        sel = kind_e'(2'(k));
      end
    end
    sel_onehot = NUM_EVENTS'(1) << sel;
  end

  // Hand-off and reload of the event slot.
  always_comb begin
    out_load      = !out_valid_q || !out_stall_i;
    emit          = out_load && (mask_q != '0);
    pending_after = emit ? (mask_q & ~sel_onehot) : mask_q;
    stat_o.slot_free = (pending_after == '0);
    stat_o.load      = s2_valid_i && stat_o.slot_free;
    stat_o.pending   = (mask_q != '0);
    mask_d = stat_o.load ? new_mask : pending_after;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_load) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Event values and the output register.
  always_ff @(posedge clk_i) begin
    if (stat_o.load) begin
      for (int k = 0; k < NUM_EVENTS; k++) begin
        vals_q[k] <= vals_d[k];
      end
    end
    if (emit) begin
      kind_q  <= sel;
      value_q <= vals_q[sel];
      last_q  <= (pending_after == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign event_value_o = value_q;
  assign last_event_o  = last_q;

endmodule

### rtl/gamepad_axis_throttle_mapper.sv
// ----------------------------------------------------------------------------
// Gamepad axis throttle mapper
// Turns gamepad reports into throttle level events for three axes and a
// shoulder button event, using four stick lanes and a merge stage.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid_i / in_stall_o   | five report bytes
//  out      | out_valid_o / out_stall_i | event_kind_o, event_value_o,
//           |                           | last_event_o
//  cfg      | cfg_valid_i / cfg_ready_o | power_levels_i
//
// A report passes two lane stages and the merge stage before its first event
// is loaded into the output register.
// The merge stage releases one event per cycle while the output does not stall;
// a report causes at most four events, and may cause none.
// Reset clears the stored report, levels, button value and all valid state;
// power_levels returns to 10. No clearing pass is needed.
// A stall on the output holds the output register; the pipeline behind it
// keeps filling until every stage holds a report, then in_stall_o rises.
`timescale 1ns / 1ps

module gamepad_axis_throttle_mapper import gatm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [BYTE_W-1:0]         power_levels_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [BYTE_W-1:0]         left_stick_x_i,
  input  logic [BYTE_W-1:0]         left_stick_y_i,
  input  logic [BYTE_W-1:0]         right_stick_x_i,
  input  logic [BYTE_W-1:0]         right_stick_y_i,
  input  logic [BYTE_W-1:0]         shoulder_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                event_kind_o,
  output logic signed [VALUE_W-1:0] event_value_o,
  output logic                      last_event_o
);

  `include "gamepad_axis_throttle_mapper_defines.svh"

  logic [BYTE_W-1:0] power_q;
  logic [BYTE_W-1:0] stick_bytes [NUM_STICKS];
  lane_ctrl_t        lane_ctrl;
  lane_stat_t        lane_stat [NUM_STICKS];
  merge_stat_t       merge_stat;

  logic              accept, s2_ready, adv12;
  logic              s1_valid_q, s1_valid_d;
  logic              s2_valid_q, s2_valid_d;

  logic [BYTE_W-1:0] prev_shoulder_q;
  logic [BYTE_W-1:0] prev_btn_q;
  logic              btn_emit, btn_val;
  logic              btn_emit1_q, btn_val1_q;
  logic              btn_emit2_q, btn_val2_q;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= POWER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      power_q <= power_levels_i;
    end
  end

  // Pipeline control: each stage moves on when the one after it frees up.
  always_comb begin
    s2_ready   = !s2_valid_q || merge_stat.slot_free;
    adv12      = s1_valid_q && s2_ready;
    in_stall_o = s1_valid_q && !s2_ready;
    accept     = in_valid_i && !in_stall_o;
    lane_ctrl.en1 = accept;
    lane_ctrl.en2 = adv12;
    lane_ctrl.en3 = merge_stat.load;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv12) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (adv12) begin
      s2_valid_d = 1'b1;
    end else if (merge_stat.load) begin
      s2_valid_d = 1'b0;
    end else begin
      s2_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Stick lanes.
  assign stick_bytes[0] = left_stick_x_i;
  assign stick_bytes[1] = left_stick_y_i;
  assign stick_bytes[2] = right_stick_x_i;
  assign stick_bytes[3] = right_stick_y_i;

  for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
    gatm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .byte_i       (stick_bytes[g]),
      .half_power_i (power_q[BYTE_W-1:1]),
      .stat_o       (lane_stat[g])
    );
  end

  // Button path: decided at the transfer, since it depends on no level.
  always_comb begin
    btn_emit = (shoulder_byte_i != prev_shoulder_q) && (shoulder_byte_i != prev_btn_q);
    btn_val  = !((shoulder_byte_i == BTN_LEFT) || (shoulder_byte_i == BTN_RIGHT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_shoulder_q <= BYTE_RESET;
      prev_btn_q      <= '0;
    end else if (accept) begin
      prev_shoulder_q <= shoulder_byte_i;
      if (btn_emit) begin
        prev_btn_q <= shoulder_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      btn_emit1_q <= btn_emit;
      btn_val1_q  <= btn_val;
    end
    if (adv12) begin
      btn_emit2_q <= btn_emit1_q;
      btn_val2_q  <= btn_val1_q;
    end
  end

  // Merge stage and output register.
  gatm_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s2_valid_i    (s2_valid_q),
    .lane_i        (lane_stat),
    .btn_emit_i    (btn_emit2_q),
    .btn_val_i     (btn_val2_q),
    .stat_o        (merge_stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_value_o (event_value_o),
    .last_event_o  (last_event_o)
  );

  // An accepted report always lands in the first stage.
  `GATM_ASSERT(a_accept_lands, accept |=> s1_valid_q, "accepted report lost at stage 1")
  // An event that is not the last leaves further events waiting in the merge stage.
  `GATM_ASSERT(a_more_pending, (out_valid_o && !last_event_o) |-> merge_stat.pending,
               "event not marked last but nothing pending")
  // Button events carry only 0 or 1.
  `GATM_ASSERT_NEVER(a_button_value,
                     out_valid_o && (event_kind_o == KIND_BUTTON) && (event_value_o[8:1] != '0),
                     "button event value out of range")

endmodule
